// File: design/pma_pkg.sv
package pma_pkg;

    localparam int SENSOR_W = 14;              // raw sensor delta
    localparam int DELTA_W  = SENSOR_W + 1;    // sensor delta after optional negation
    localparam int SMOOTH_W = 16;              // exponential average state
    localparam int AXIS_W   = 14;              // smoothed delta, state / 4
    localparam int SPEED_W  = 14;              // magnitude of a smoothed delta
    localparam int PROD_W   = 2 * SPEED_W;     // signed product plus remainder
    localparam int MAG_W    = PROD_W - 1;      // magnitude of that sum
    localparam int REM_W    = 7;               // carried remainder, |r| < 64
    localparam int SCALE_W  = 7;               // divisor 1..64
    localparam int LEVEL_W  = 7;
    localparam int CURSOR_W = 8;
    localparam int CNT_W    = 5;

    localparam logic [CURSOR_W-2:0] CURSOR_MAX = 7'd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_QUARTER,
        ST_DECIDE,
        ST_ACCEL,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        AX_IDLE,
        AX_MUL,
        AX_ADD,
        AX_ABS,
        AX_DIV
    } t_axis_phase;

    typedef struct packed {
        logic               start;
        logic [SPEED_W-1:0] speed;
        logic [SCALE_W-1:0] scale;
    } t_axis_req;

    // Divisor 64 / level, truncated; levels above 64 act as 64.
    function automatic logic [SCALE_W-1:0] scale_of(input logic [LEVEL_W-1:0] level);
        logic [SCALE_W-1:0] s;
        case (level) inside
            [7'd33:7'd127]: s = 7'd1;
            [7'd22:7'd32]:  s = 7'd2;
            [7'd17:7'd21]:  s = 7'd3;
            [7'd13:7'd16]:  s = 7'd4;
            [7'd11:7'd12]:  s = 7'd5;
            7'd10:          s = 7'd6;
            7'd9:           s = 7'd7;
            7'd8:           s = 7'd8;
            7'd7:           s = 7'd9;
            7'd6:           s = 7'd10;
            7'd5:           s = 7'd12;
            7'd4:           s = 7'd16;
            7'd3:           s = 7'd21;
            7'd2:           s = 7'd32;
            default:        s = 7'd64;
        endcase
        return s;
    endfunction

endpackage

// File: design/pointer_motion_accelerator.sv
// Pointer motion accelerator.
// Input channel (i_in_valid / o_in_ready) takes one sensor delta pair and a
// side flag; output channel (o_out_valid / i_out_ready) gives one cursor
// movement per item, in order. i_cfg_we writes the acceleration level from
// i_cfg_data at once; write it only while no item is in flight.
// With acceleration on, the time from acceptance to o_out_valid is set by the
// two bit-serial axis units (a shift-add multiply, then a restoring divide,
// both axes side by side). With the level at 0, or with no motion, both axis
// units are skipped and the smoothed deltas pass, saturated, to the result.
// One item is worked on at a time; a new item is accepted the cycle after the
// previous result has moved into the output register.
// The output register holds its result while i_out_ready is low; the next item
// is still accepted and runs to completion, then waits until the register
// frees. Reset clears the level to 0, all averages and remainders to 0, and
// leaves both channels empty.
module pointer_motion_accelerator #(
    parameter int SIDE_COUNT = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pma_pkg::LEVEL_W-1:0]           i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [pma_pkg::SENSOR_W-1:0]   i_sensor_x,
    input  logic signed [pma_pkg::SENSOR_W-1:0]   i_sensor_y,
    input  logic                                  i_right_side,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [pma_pkg::CURSOR_W-1:0]   o_cursor_x,
    output logic signed [pma_pkg::CURSOR_W-1:0]   o_cursor_y
);

    localparam int SIDE_W   = (SIDE_COUNT > 1) ? $clog2(SIDE_COUNT) : 1;
    localparam int DELTA_W  = pma_pkg::DELTA_W;
    localparam int SMOOTH_W = pma_pkg::SMOOTH_W;
    localparam int AXIS_W   = pma_pkg::AXIS_W;
    localparam int REM_W    = pma_pkg::REM_W;
    localparam int CURSOR_W = pma_pkg::CURSOR_W;
    localparam int LEVEL_W  = pma_pkg::LEVEL_W;

    pma_pkg::t_state              r_state, n_state;
    logic [LEVEL_W-1:0]           r_level;
    logic [SIDE_W-1:0]            r_side, n_side;
    logic signed [DELTA_W-1:0]    r_dh, n_dh, r_dv, n_dv;
    logic signed [AXIS_W-1:0]     r_ah, n_ah, r_av, n_av;
    logic [SMOOTH_W-1:0]          r_sm_h [SIDE_COUNT];
    logic [SMOOTH_W-1:0]          n_sm_h [SIDE_COUNT];
    logic [SMOOTH_W-1:0]          r_sm_v [SIDE_COUNT];
    logic [SMOOTH_W-1:0]          n_sm_v [SIDE_COUNT];
    logic signed [REM_W-1:0]      r_rem_h [SIDE_COUNT];
    logic signed [REM_W-1:0]      n_rem_h [SIDE_COUNT];
    logic signed [REM_W-1:0]      r_rem_v [SIDE_COUNT];
    logic signed [REM_W-1:0]      n_rem_v [SIDE_COUNT];
    logic signed [CURSOR_W-1:0]   r_res_h, n_res_h, r_res_v, n_res_v;
    logic                         r_out_valid, n_out_valid;
    logic signed [CURSOR_W-1:0]   r_out_x, n_out_x, r_out_y, n_out_y;
    pma_pkg::t_axis_req           r_req, n_req;

    logic signed [DELTA_W-1:0]    ext_h, ext_v;
    logic [AXIS_W-1:0]            abs_h, abs_v, speed;
    logic                         done_h, done_v;
    logic signed [CURSOR_W-1:0]   quot_h, quot_v;
    logic signed [REM_W-1:0]      rem_h_new, rem_v_new;

    // s + d - s/4, wrapping in 16 bits
    function automatic logic [SMOOTH_W-1:0] ema_next(input logic [SMOOTH_W-1:0] e,
                                                     input logic [DELTA_W-1:0] d);
        logic [SMOOTH_W-1:0] e_bias;
        logic [SMOOTH_W-1:0] e_q;
        e_bias = e + (e[SMOOTH_W-1] ? SMOOTH_W'(3) : '0);
        e_q    = {{2{e_bias[SMOOTH_W-1]}}, e_bias[SMOOTH_W-1:2]};
        return e + {{(SMOOTH_W-DELTA_W){d[DELTA_W-1]}}, d} - e_q;
    endfunction

    // s / 4, truncating toward zero
    function automatic logic [AXIS_W-1:0] quarter(input logic [SMOOTH_W-1:0] s);
        logic [SMOOTH_W-1:0] b;
        b = s + (s[SMOOTH_W-1] ? SMOOTH_W'(3) : '0);
        return b[SMOOTH_W-1:2];
    endfunction

    function automatic logic [CURSOR_W-1:0] sat_cursor(input logic signed [AXIS_W-1:0] v);
        logic [CURSOR_W-1:0] r;
        if (v > $signed({1'b0, AXIS_W'(pma_pkg::CURSOR_MAX)})) begin
            r = {1'b0, pma_pkg::CURSOR_MAX};
        end else if (v < -$signed({1'b0, AXIS_W'(pma_pkg::CURSOR_MAX)})) begin
            r = -{1'b0, pma_pkg::CURSOR_MAX};
        end else begin
            r = v[CURSOR_W-1:0];
        end
        return r;
    endfunction

    pma_axis_unit u_axis_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_delta (r_ah),
        .i_rem   (r_rem_h[r_side]),
        .o_done  (done_h),
        .o_quot  (quot_h),
        .o_rem   (rem_h_new)
    );

    pma_axis_unit u_axis_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_delta (r_av),
        .i_rem   (r_rem_v[r_side]),
        .o_done  (done_v),
        .o_quot  (quot_v),
        .o_rem   (rem_v_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pma_pkg::ST_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
            r_req       <= '0;
            r_sm_h      <= '{default: '0};
            r_sm_v      <= '{default: '0};
            r_rem_h     <= '{default: '0};
            r_rem_v     <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_req       <= n_req;
            r_sm_h      <= n_sm_h;
            r_sm_v      <= n_sm_v;
            r_rem_h     <= n_rem_h;
            r_rem_v     <= n_rem_v;
            if (i_cfg_we) begin
                r_level <= i_cfg_data;
            end
        end
        r_side  <= n_side;
        r_dh    <= n_dh;
        r_dv    <= n_dv;
        r_ah    <= n_ah;
        r_av    <= n_av;
        r_res_h <= n_res_h;
        r_res_v <= n_res_v;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    always_comb begin
        n_state     = r_state;
        n_side      = r_side;
        n_dh        = r_dh;
        n_dv        = r_dv;
        n_ah        = r_ah;
        n_av        = r_av;
        n_sm_h      = r_sm_h;
        n_sm_v      = r_sm_v;
        n_rem_h     = r_rem_h;
        n_rem_v     = r_rem_v;
        n_res_h     = r_res_h;
        n_res_v     = r_res_v;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_req       = '0;
        n_out_valid = r_out_valid && !i_out_ready;

        // sensor y drives the horizontal axis, sensor x the vertical one
        ext_h = {i_sensor_y[pma_pkg::SENSOR_W-1], i_sensor_y};
        ext_v = {i_sensor_x[pma_pkg::SENSOR_W-1], i_sensor_x};
        abs_h = r_ah[AXIS_W-1] ? (~r_ah + 1'b1) : r_ah;
        abs_v = r_av[AXIS_W-1] ? (~r_av + 1'b1) : r_av;
        speed = (abs_h > abs_v) ? abs_h : abs_v;

        o_in_ready = (r_state == pma_pkg::ST_IDLE);

        case (r_state)
            pma_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_side  = (SIDE_COUNT > 1) ? SIDE_W'(i_right_side) : '0;
                    n_dh    = i_right_side ? -ext_h : ext_h;
                    n_dv    = i_right_side ? -ext_v : ext_v;
                    n_state = pma_pkg::ST_SMOOTH;
                end
            end
            pma_pkg::ST_SMOOTH: begin
                n_sm_h[r_side] = ema_next(r_sm_h[r_side], r_dh);
                n_sm_v[r_side] = ema_next(r_sm_v[r_side], r_dv);
                n_state        = pma_pkg::ST_QUARTER;
            end
            pma_pkg::ST_QUARTER: begin
                n_ah    = quarter(r_sm_h[r_side]);
                n_av    = quarter(r_sm_v[r_side]);
                n_state = pma_pkg::ST_DECIDE;
            end
            pma_pkg::ST_DECIDE: begin
                if (r_level == '0 || speed == '0) begin
                    // no acceleration: pass the smoothed deltas, drop the remainders
                    n_rem_h[r_side] = '0;
                    n_rem_v[r_side] = '0;
                    n_res_h         = sat_cursor(r_ah);
                    n_res_v         = sat_cursor(r_av);
                    n_state         = pma_pkg::ST_DONE;
                end else begin
                    n_req.start = 1'b1;
                    n_req.speed = speed;
                    n_req.scale = pma_pkg::scale_of(r_level);
                    n_state     = pma_pkg::ST_ACCEL;
                end
            end
            pma_pkg::ST_ACCEL: begin
                if (done_h && done_v) begin
                    n_rem_h[r_side] = rem_h_new;
                    n_rem_v[r_side] = rem_v_new;
                    n_res_h         = quot_h;
                    n_res_v         = quot_v;
                    n_state         = pma_pkg::ST_DONE;
                end
            end
            pma_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_res_h;
                    n_out_y     = r_res_v;
                    n_state     = pma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pma_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_cursor_x  = r_out_x;
    assign o_cursor_y  = r_out_y;

endmodule

// File: design/pma_axis_unit.sv
module pma_axis_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pma_pkg::t_axis_req                    i_req,
    input  logic signed [pma_pkg::AXIS_W-1:0]     i_delta,
    input  logic signed [pma_pkg::REM_W-1:0]      i_rem,
    output logic                                  o_done,
    output logic signed [pma_pkg::CURSOR_W-1:0]   o_quot,
    output logic signed [pma_pkg::REM_W-1:0]      o_rem
);

    localparam int SPEED_W  = pma_pkg::SPEED_W;
    localparam int PROD_W   = pma_pkg::PROD_W;
    localparam int MAG_W    = pma_pkg::MAG_W;
    localparam int REM_W    = pma_pkg::REM_W;
    localparam int SCALE_W  = pma_pkg::SCALE_W;
    localparam int CNT_W    = pma_pkg::CNT_W;
    localparam int QMAG_W   = pma_pkg::CURSOR_W - 1;

    pma_pkg::t_axis_phase r_phase, n_phase;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [SPEED_W-1:0]   r_mcand, n_mcand;
    logic [SPEED_W-1:0]   r_hi, n_hi;
    logic [SPEED_W-1:0]   r_lo, n_lo;
    logic                 r_neg, n_neg;
    logic [REM_W-1:0]     r_rem_in, n_rem_in;
    logic [SCALE_W-1:0]   r_scale, n_scale;
    logic [PROD_W-1:0]    r_p, n_p;
    logic [MAG_W-1:0]     r_dvd, n_dvd;
    logic [REM_W-1:0]     r_part, n_part;
    logic                 r_pneg, n_pneg;

    logic [SPEED_W:0]     mul_sum;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    p_sum;
    logic [PROD_W-1:0]    p_mag;
    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic                 ge;
    logic [SPEED_W-1:0]   delta_mag;
    logic [QMAG_W-1:0]    q_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pma_pkg::AX_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_mcand  <= n_mcand;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_neg    <= n_neg;
        r_rem_in <= n_rem_in;
        r_scale  <= n_scale;
        r_p      <= n_p;
        r_dvd    <= n_dvd;
        r_part   <= n_part;
        r_pneg   <= n_pneg;
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_mcand  = r_mcand;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_neg    = r_neg;
        n_rem_in = r_rem_in;
        n_scale  = r_scale;
        n_p      = r_p;
        n_dvd    = r_dvd;
        n_part   = r_part;
        n_pneg   = r_pneg;

        delta_mag = i_delta[SPEED_W-1] ? (~i_delta + 1'b1) : i_delta;
        mul_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);
        prod      = {r_hi, r_lo};
        // signed product as invert plus carry-in, then add the carried remainder
        p_sum     = (r_neg ? ~prod : prod) + PROD_W'(r_neg)
                    + {{(PROD_W-REM_W){r_rem_in[REM_W-1]}}, r_rem_in};
        p_mag     = r_p[PROD_W-1] ? (~r_p + 1'b1) : r_p;
        trial     = {r_part, r_dvd[MAG_W-1]};
        diff      = trial - {1'b0, r_scale};
        ge        = (trial >= {1'b0, r_scale});

        case (r_phase)
            pma_pkg::AX_IDLE: begin
                if (i_req.start) begin
                    n_mcand  = delta_mag;
                    n_neg    = i_delta[SPEED_W-1];
                    n_hi     = '0;
                    n_lo     = i_req.speed;
                    n_scale  = i_req.scale;
                    n_rem_in = i_rem;
                    n_cnt    = '0;
                    n_phase  = pma_pkg::AX_MUL;
                end
            end
            pma_pkg::AX_MUL: begin
                // shift-add, one multiplier bit per cycle
                n_hi  = mul_sum[SPEED_W:1];
                n_lo  = {mul_sum[0], r_lo[SPEED_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SPEED_W - 1)) begin
                    n_phase = pma_pkg::AX_ADD;
                end
            end
            pma_pkg::AX_ADD: begin
                n_p     = p_sum;
                n_phase = pma_pkg::AX_ABS;
            end
            pma_pkg::AX_ABS: begin
                n_dvd   = p_mag[MAG_W-1:0];
                n_pneg  = r_p[PROD_W-1];
                n_part  = '0;
                n_cnt   = '0;
                n_phase = pma_pkg::AX_DIV;
            end
            pma_pkg::AX_DIV: begin
                // restoring divide, quotient bits shift in behind the dividend
                n_part = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                n_dvd  = {r_dvd[MAG_W-2:0], ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    n_done  = 1'b1;
                    n_phase = pma_pkg::AX_IDLE;
                end
            end
            default: begin
                n_phase = pma_pkg::AX_IDLE;
            end
        endcase
    end

    // quotient and remainder take the sign of the dividend (truncating divide)
    assign q_mag  = (|r_dvd[MAG_W-1:QMAG_W]) ? pma_pkg::CURSOR_MAX : r_dvd[QMAG_W-1:0];
    assign o_quot = r_pneg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign o_rem  = r_pneg ? -$signed(r_part) : $signed(r_part);
    assign o_done = r_done;

endmodule
